[rtl/lcdnb_pkg.sv]
`timescale 1ns / 1ps

package lcdnb_pkg;

  localparam int unsigned DefMaxMoves = 15;

  localparam logic [7:0] ByteTab        = 8'h09;
  localparam logic [7:0] CmdClear       = 8'h01;
  localparam logic [7:0] CmdHome        = 8'h02;
  localparam logic [7:0] CmdMoveLeft    = 8'h10;
  localparam logic [7:0] CmdMoveRight   = 8'h14;
  localparam logic [7:0] CmdSetCgram    = 8'h40;
  localparam logic [7:0] CmdSetDdram    = 8'h80;
  localparam logic [7:0] RowOddOffset   = 8'h40;
  localparam logic [7:0] FlagDisplayOn  = 8'h04;
  localparam logic [7:0] FlagsReset     = 8'h08;

  typedef enum logic [3:0] {
    MODE_CHAR      = 4'd0,
    MODE_CMD       = 4'd1,
    MODE_CURSOR    = 4'd2,
    MODE_FLAG      = 4'd3,
    MODE_LEFT      = 4'd4,
    MODE_RIGHT     = 4'd5,
    MODE_CLEAR     = 4'd6,
    MODE_HOME      = 4'd7,
    MODE_BACKLIGHT = 4'd8,
    MODE_CGRAM     = 4'd9,
    MODE_DATA      = 4'd10,
    MODE_NIBBLE    = 4'd11
  } mode_e;

  typedef enum logic [2:0] {
    REG_COLUMNS   = 3'd0,
    REG_ROWS      = 3'd1,
    REG_ENABLE    = 3'd2,
    REG_SELECT    = 3'd3,
    REG_PIN_MAP   = 3'd4,
    REG_BL_BIT    = 3'd5,
    REG_BL_POL    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] value;
    logic [5:0] col;
    logic [2:0] row;
    logic [3:0] count;
    logic [1:0] flag_index;
    logic       flag_on;
  } in_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       end_of_transfer;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [6:0]  columns;
    logic [2:0]  rows_in_use;
    logic [2:0]  enable_bit;
    logic [2:0]  select_bit;
    logic [11:0] data_pin_map;
    logic [2:0]  backlight_bit;
    logic        backlight_polarity;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       eval;
    logic       emit;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic send_now;
    logic nibble;
    logic final_send;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] map_nibble(input logic [3:0] nib, input logic [11:0] pin_map);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (nib[i]) begin
        r = r | (8'h01 << pin_map[3*i +: 3]);
      end
    end
    return r;
  endfunction

endpackage

[rtl/lcdnb_cfg.sv]
`timescale 1ns / 1ps

module lcdnb_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i,
  output lcdnb_pkg::cfg_t    cfg_o
);

  lcdnb_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns            <= 7'd20;
      cfg_q.rows_in_use        <= 3'd4;
      cfg_q.enable_bit         <= 3'd2;
      cfg_q.select_bit         <= 3'd0;
      cfg_q.data_pin_map       <= 12'd4012;
      cfg_q.backlight_bit      <= 3'd3;
      cfg_q.backlight_polarity <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (lcdnb_pkg::cfg_idx_e'(cfg_index_i))
        lcdnb_pkg::REG_COLUMNS: cfg_q.columns            <= cfg_data_i[6:0];
        lcdnb_pkg::REG_ROWS:    cfg_q.rows_in_use        <= cfg_data_i[2:0];
        lcdnb_pkg::REG_ENABLE:  cfg_q.enable_bit         <= cfg_data_i[2:0];
        lcdnb_pkg::REG_SELECT:  cfg_q.select_bit         <= cfg_data_i[2:0];
        lcdnb_pkg::REG_PIN_MAP: cfg_q.data_pin_map       <= cfg_data_i;
        lcdnb_pkg::REG_BL_BIT:  cfg_q.backlight_bit      <= cfg_data_i[2:0];
        lcdnb_pkg::REG_BL_POL:  cfg_q.backlight_polarity <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/lcdnb_ctrl.sv]
`timescale 1ns / 1ps

module lcdnb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lcdnb_pkg::sts_t sts_i,
  output lcdnb_pkg::cmd_t cmd_o
);

  lcdnb_pkg::state_e state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [1:0]        end_phase;

  assign end_phase = sts_i.nibble ? 2'd1 : 2'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcdnb_pkg::ST_IDLE;
      phase_q <= 2'd0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      lcdnb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lcdnb_pkg::ST_EVAL;
        end
      end
      lcdnb_pkg::ST_EVAL: begin
        phase_d = 2'd0;
        state_d = sts_i.send_now ? lcdnb_pkg::ST_SEND : lcdnb_pkg::ST_IDLE;
      end
      lcdnb_pkg::ST_SEND: begin
        if (sts_i.out_free) begin
          phase_d = phase_q + 2'd1;
          if (phase_q == end_phase) begin
            state_d = sts_i.final_send ? lcdnb_pkg::ST_IDLE : lcdnb_pkg::ST_EVAL;
          end
        end
      end
      default: state_d = lcdnb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != lcdnb_pkg::ST_IDLE);
    cmd_o.load   = (state_q == lcdnb_pkg::ST_IDLE) && in_valid_i;
    cmd_o.eval   = (state_q == lcdnb_pkg::ST_EVAL);
    cmd_o.emit   = (state_q == lcdnb_pkg::ST_SEND) && sts_i.out_free;
    cmd_o.phase  = phase_q;
  end

endmodule

[rtl/lcdnb_dp.sv]
`timescale 1ns / 1ps

module lcdnb_dp #(
  parameter int unsigned MaxMoves = lcdnb_pkg::DefMaxMoves
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lcdnb_pkg::cfg_t cfg_i,
  input  lcdnb_pkg::in_t  in_data_i,
  input  lcdnb_pkg::cmd_t cmd_i,
  output lcdnb_pkg::sts_t sts_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output lcdnb_pkg::out_t out_data_o
);

  lcdnb_pkg::in_t  it_q;
  logic [3:0]      cnt_q;
  logic [6:0]      cur_q;
  logic [7:0]      flags_q;
  logic            bl_q;
  logic [7:0]      byte_q;
  logic [7:0]      base_q;
  logic            nibble_q;
  logic            final_q;
  logic            out_valid_q;
  lcdnb_pkg::out_t out_q;

  // evaluation of the next send
  logic       ev_send;
  logic       ev_data;
  logic       ev_nibble;
  logic       ev_more;
  logic [7:0] ev_byte;
  logic [6:0] ev_cur;
  logic [7:0] ev_flags;
  logic       ev_bl;
  logic [7:0] ev_base;
  logic [6:0] cur_inc;
  logic [6:0] cur_dec;
  logic [3:0] cnt_dec;
  logic [7:0] fmask;
  logic [7:0] offset;
  logic [3:0] count_clamped;

  assign cur_inc = cur_q + 7'd1;
  assign cur_dec = cur_q - 7'd1;
  assign cnt_dec = cnt_q - 4'd1;
  assign fmask   = 8'h01 << it_q.flag_index;
  assign offset  = {2'b00, it_q.col}
                 + (it_q.row[0] ? lcdnb_pkg::RowOddOffset : 8'h00)
                 + (it_q.row[1] ? {1'b0, cfg_i.columns} : 8'h00);
  assign count_clamped = (in_data_i.count > 4'(MaxMoves)) ? 4'(MaxMoves) : in_data_i.count;

  always_comb begin
    ev_send   = 1'b0;
    ev_data   = 1'b0;
    ev_nibble = 1'b0;
    ev_more   = 1'b0;
    ev_byte   = 8'h00;
    ev_cur    = cur_q;
    ev_flags  = flags_q;
    ev_bl     = bl_q;
    unique case (lcdnb_pkg::mode_e'(it_q.mode))
      lcdnb_pkg::MODE_CHAR: begin
        ev_cur = cur_inc;
        if (it_q.value == lcdnb_pkg::ByteTab) begin
          ev_send = (cur_q[1:0] != 2'd0) && (cur_q < cfg_i.columns);
          ev_byte = lcdnb_pkg::CmdMoveRight;
          ev_more = (cur_inc[1:0] != 2'd0) && (cur_inc < cfg_i.columns);
        end else begin
          ev_send = (cur_q < cfg_i.columns);
          ev_byte = it_q.value;
          ev_data = 1'b1;
        end
      end
      lcdnb_pkg::MODE_CMD: begin
        ev_send = 1'b1;
        ev_byte = it_q.value;
      end
      lcdnb_pkg::MODE_CURSOR: begin
        ev_send = ({1'b0, it_q.col} < cfg_i.columns) && (it_q.row < cfg_i.rows_in_use);
        ev_byte = lcdnb_pkg::CmdSetDdram | offset;
        ev_cur  = {1'b0, it_q.col};
      end
      lcdnb_pkg::MODE_FLAG: begin
        ev_send  = (it_q.flag_index != 2'd3);
        ev_flags = it_q.flag_on ? (flags_q | fmask) : (flags_q & ~fmask);
        ev_byte  = ev_flags;
      end
      lcdnb_pkg::MODE_LEFT: begin
        ev_send = (cnt_q != 4'd0) && (cur_q != 7'd0);
        ev_byte = lcdnb_pkg::CmdMoveLeft;
        ev_cur  = cur_dec;
        ev_more = (cnt_dec != 4'd0) && (cur_dec != 7'd0);
      end
      lcdnb_pkg::MODE_RIGHT: begin
        ev_send = (cnt_q != 4'd0) && (cur_q < cfg_i.columns);
        ev_byte = lcdnb_pkg::CmdMoveRight;
        ev_cur  = cur_inc;
        ev_more = (cnt_dec != 4'd0) && (cur_inc < cfg_i.columns);
      end
      lcdnb_pkg::MODE_CLEAR: begin
        ev_send = 1'b1;
        ev_byte = lcdnb_pkg::CmdClear;
        ev_cur  = 7'd0;
      end
      lcdnb_pkg::MODE_HOME: begin
        ev_send = 1'b1;
        ev_byte = lcdnb_pkg::CmdHome;
        ev_cur  = 7'd0;
      end
      lcdnb_pkg::MODE_BACKLIGHT: begin
        ev_send  = 1'b1;
        ev_bl    = (it_q.flag_on == cfg_i.backlight_polarity);
        ev_flags = ev_bl ? (flags_q | lcdnb_pkg::FlagDisplayOn)
                         : (flags_q & ~lcdnb_pkg::FlagDisplayOn);
        ev_byte  = ev_flags;
      end
      lcdnb_pkg::MODE_CGRAM: begin
        ev_send = 1'b1;
        ev_byte = lcdnb_pkg::CmdSetCgram | {2'b00, it_q.value[2:0], 3'b000};
      end
      lcdnb_pkg::MODE_DATA: begin
        ev_send = 1'b1;
        ev_byte = it_q.value;
        ev_data = 1'b1;
      end
      lcdnb_pkg::MODE_NIBBLE: begin
        ev_send   = 1'b1;
        ev_nibble = 1'b1;
        ev_byte   = {it_q.value[3:0], it_q.value[3:0]};
      end
      default: ;
    endcase
    ev_base = (ev_data ? (8'h01 << cfg_i.select_bit) : 8'h00)
            | (ev_bl ? (8'h01 << cfg_i.backlight_bit) : 8'h00);
    if (ev_nibble) begin
      ev_base = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= 7'd0;
      flags_q <= lcdnb_pkg::FlagsReset;
      bl_q    <= 1'b0;
    end else if (cmd_i.eval && ev_send) begin
      cur_q   <= ev_cur;
      flags_q <= ev_flags;
      bl_q    <= ev_bl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q  <= in_data_i;
      cnt_q <= count_clamped;
    end else if (cmd_i.eval) begin
      cnt_q <= cnt_dec;
    end
    if (cmd_i.eval) begin
      byte_q   <= ev_byte;
      base_q   <= ev_base;
      nibble_q <= ev_nibble;
      final_q  <= !ev_more;
    end
  end

  // byte assembly for the current phase
  logic [3:0] sel_nib;
  logic [7:0] pattern;
  logic [7:0] en_mask;

  assign sel_nib = cmd_i.phase[1] ? byte_q[3:0] : byte_q[7:4];
  assign pattern = base_q | lcdnb_pkg::map_nibble(sel_nib, cfg_i.data_pin_map);
  assign en_mask = 8'h01 << cfg_i.enable_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.bus_byte        <= cmd_i.phase[0] ? pattern : (pattern | en_mask);
      out_q.end_of_transfer <= nibble_q || (cmd_i.phase == 2'd3);
      out_q.last            <= final_q && (nibble_q ? (cmd_i.phase == 2'd1)
                                                    : (cmd_i.phase == 2'd3));
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign sts_o.send_now    = ev_send;
  assign sts_o.nibble      = nibble_q;
  assign sts_o.final_send  = final_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

[rtl/char_lcd_nibble_bus_encoder_unit.sv]
`timescale 1ns / 1ps
// flow: the item is loaded while idle, evaluated in the EVAL state, then its bytes are registered in SEND
// each lcd send is one evaluation followed by four expander bytes, an init nibble by two bytes
// an item may make several sends (repeated moves, tabs) or none, then the block returns to idle
// output stalls hold the SEND state; one item is worked on at a time
// reset: cursor column 0, display flags 0x08, backlight off, configuration to defaults
module char_lcd_nibble_bus_encoder_unit #(
  parameter int unsigned MaxMoves = lcdnb_pkg::DefMaxMoves
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lcdnb_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lcdnb_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [11:0]     cfg_data_i
);

  lcdnb_pkg::cfg_t cfg;
  lcdnb_pkg::cmd_t cmd;
  lcdnb_pkg::sts_t sts;

  lcdnb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lcdnb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcdnb_dp #(
    .MaxMoves (MaxMoves)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken without going busy");

  a_send_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.end_of_transfer |=> out_valid_o)
    else $error("gap inside an lcd send");

  a_pending_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("block idle with item results still to come");

  a_last_has_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.end_of_transfer)
    else $error("final byte without bus stop");

endmodule
